@@ src/cmfs_pkg.sv @@
`timescale 1ns / 1ps

package cmfs_pkg;

  // Width of one direction component as read from the ports.
  localparam int CompBits = 16;
  // Fraction bits of a face coordinate.
  localparam int FracBits = 16;
  // Width of the tex_u and tex_v ports.
  localparam int TexW = 16;

  // Working width of the dividend and remainder: values up to twice the major magnitude.
  localparam int NW = CompBits + 1;

  // The divider retires this many quotient bits in each pipeline stage.
  localparam int StepsPerStage = 4;
  localparam int NumDivStages = (FracBits + StepsPerStage - 1) / StepsPerStage;
  localparam int QW = NumDivStages * StepsPerStage;
  // Quotient bits computed beyond the fraction width, dropped at the output.
  localparam int ExtraBits = QW - FracBits;

  typedef enum logic [2:0] {
    FacePosX = 3'd0,
    FaceNegX = 3'd1,
    FacePosY = 3'd2,
    FaceNegY = 3'd3,
    FacePosZ = 3'd4,
    FaceNegZ = 3'd5
  } face_e;

  // Payload that travels down the divider pipeline.
  typedef struct packed {
    logic             res_valid;
    face_e            face;
    logic [CompBits-1:0] m;
    logic [NW-1:0]    ru;
    logic [NW-1:0]    rv;
    logic [QW-1:0]    qu;
    logic [QW-1:0]    qv;
  } stage_t;

  // Result of one restoring division step.
  typedef struct packed {
    logic          qbit;
    logic [NW-1:0] rem;
  } div_step_t;

  // One restoring step: compare the partial remainder with m, subtract
  // when it fits, and shift for the next bit. The remainder never exceeds 2m.
  function automatic div_step_t div_step(input logic [NW-1:0] r,
                                         input logic [CompBits-1:0] m);
    logic [NW-1:0] mx;
    logic [NW-1:0] diff;
    div_step_t     res;
    mx       = {1'b0, m};
    res.qbit = (r >= mx);
    diff     = res.qbit ? (r - mx) : r;
    res.rem  = {diff[NW-2:0], 1'b0};
    return res;
  endfunction

endpackage

@@ src/cmfs_select.sv @@
`timescale 1ns / 1ps

module cmfs_select import cmfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                adv_i,
  input  logic                valid_i,
  input  logic [CompBits-1:0] dir_x_i,
  input  logic [CompBits-1:0] dir_y_i,
  input  logic [CompBits-1:0] dir_z_i,
  output logic                valid_o,
  output stage_t              data_o
);

  logic signed [NW-1:0] x, y, z;
  logic [CompBits-1:0]  ax, ay, az, m;
  logic signed [NW-1:0] sc, tc;
  logic [NW:0]          sum_u, sum_v;
  face_e                face;
  logic                 valid_q;
  stage_t               data_d, data_q;

  // Sign extend the components and take their magnitudes.
  always_comb begin
    x  = $signed({dir_x_i[CompBits-1], dir_x_i});
    y  = $signed({dir_y_i[CompBits-1], dir_y_i});
    z  = $signed({dir_z_i[CompBits-1], dir_z_i});
    ax = dir_x_i[CompBits-1] ? (~dir_x_i + 1'b1) : dir_x_i;
    ay = dir_y_i[CompBits-1] ? (~dir_y_i + 1'b1) : dir_y_i;
    az = dir_z_i[CompBits-1] ? (~dir_z_i + 1'b1) : dir_z_i;
  end

  // Pick the major axis with ties going to x, then y, and the face operands.
  always_comb begin
    if (ax >= ay && ax >= az) begin
      m = ax;
      if (!dir_x_i[CompBits-1]) begin
        face = FacePosX;
        sc   = -z;
        tc   = -y;
      end else begin
        face = FaceNegX;
        sc   = z;
        tc   = -y;
      end
    end else if (ay >= az) begin
      m = ay;
      if (!dir_y_i[CompBits-1]) begin
        face = FacePosY;
        sc   = x;
        tc   = z;
      end else begin
        face = FaceNegY;
        sc   = x;
        tc   = -z;
      end
    end else begin
      m = az;
      if (!dir_z_i[CompBits-1]) begin
        face = FacePosZ;
        sc   = x;
        tc   = -y;
      end else begin
        face = FaceNegZ;
        sc   = -x;
        tc   = -y;
      end
    end
  end

  // Dividends c + m lie in [0, 2m] and fit in NW unsigned bits.
  always_comb begin
    sum_u            = {sc[NW-1], sc} + {2'b00, m};
    sum_v            = {tc[NW-1], tc} + {2'b00, m};
    data_d.res_valid = (m != '0);
    data_d.face      = face;
    data_d.m         = m;
    data_d.ru        = sum_u[NW-1:0];
    data_d.rv        = sum_v[NW-1:0];
    data_d.qu        = '0;
    data_d.qv        = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/cmfs_div_stage.sv @@
`timescale 1ns / 1ps

module cmfs_div_stage import cmfs_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   adv_i,
  input  logic   valid_i,
  input  stage_t data_i,
  output logic   valid_o,
  output stage_t data_o
);

  stage_t    data_d, data_q;
  logic      valid_q;
  div_step_t su, sv;

  // Retire a group of quotient bits for both coordinates in parallel.
  always_comb begin
    data_d = data_i;
    for (int i = 0; i < StepsPerStage; i++) begin
      su        = div_step(data_d.ru, data_d.m);
      sv        = div_step(data_d.rv, data_d.m);
      data_d.ru = su.rem;
      data_d.rv = sv.rem;
      data_d.qu = {data_d.qu[QW-2:0], su.qbit};
      data_d.qv = {data_d.qv[QW-2:0], sv.qbit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ src/cube_map_face_and_uv_select.sv @@
`timescale 1ns / 1ps

// Cube map face selection: takes a signed direction (dir_x_i, dir_y_i, dir_z_i), picks the
// face on the axis of largest magnitude (ties to x, then y, then z; sign picks +/- face)
// and returns face_o with coordinates tex_u_o and tex_v_o = floor((c + m) * 2^16 / (2m)),
// where a value of one saturates to 65535. A zero vector gives valid_res_o = 0 with all
// other fields 0. One item is accepted every cycle while in_stall_o is low; an item passes
// through one stage for face selection, one stage per four quotient bits of the restoring
// divider, and the output register.
// Bubbles in the pipeline close up while the output is stalled.
module cube_map_face_and_uv_select import cmfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CompBits-1:0] dir_x_i,
  input  logic [CompBits-1:0] dir_y_i,
  input  logic [CompBits-1:0] dir_z_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [2:0]          face_o,
  output logic [TexW-1:0]     tex_u_o,
  output logic [TexW-1:0]     tex_v_o,
  output logic                valid_res_o
);

  // Stage 0 is the face selector, stages 1..NumDivStages the divider.
  logic   stg_valid [NumDivStages+1];
  stage_t stg_data  [NumDivStages+1];
  logic   stg_adv   [NumDivStages+1];
  logic   out_adv;

  logic            out_valid_q;
  face_e           face_d, face_q;
  logic [TexW-1:0] tex_u_d, tex_u_q, tex_v_d, tex_v_q;
  logic            res_valid_q;
  logic [QW-1:0]   qu_sh, qv_sh;
  stage_t          last;

  // A stage moves when it is empty or the stage after it moves.
  assign out_adv = !out_valid_q || !out_stall_i;
  always_comb begin
    stg_adv[NumDivStages] = !stg_valid[NumDivStages] || out_adv;
    for (int i = NumDivStages - 1; i >= 0; i--) begin
      stg_adv[i] = !stg_valid[i] || stg_adv[i+1];
    end
  end

  assign in_stall_o = !stg_adv[0];

  cmfs_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (stg_adv[0]),
    .valid_i (in_valid_i),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (stg_valid[0]),
    .data_o  (stg_data[0])
  );

  for (genvar g = 1; g <= NumDivStages; g++) begin : g_div
    cmfs_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (stg_adv[g]),
      .valid_i (stg_valid[g-1]),
      .data_i  (stg_data[g-1]),
      .valid_o (stg_valid[g]),
      .data_o  (stg_data[g])
    );
  end

  // Drop the extra low quotient bits and clear the fields for a zero vector.
  always_comb begin
    last    = stg_data[NumDivStages];
    qu_sh   = last.qu >> ExtraBits;
    qv_sh   = last.qv >> ExtraBits;
    face_d  = last.res_valid ? last.face : FacePosX;
    tex_u_d = last.res_valid ? TexW'(qu_sh) : '0;
    tex_v_d = last.res_valid ? TexW'(qv_sh) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= stg_valid[NumDivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && stg_valid[NumDivStages]) begin
      face_q      <= face_d;
      tex_u_q     <= tex_u_d;
      tex_v_q     <= tex_v_d;
      res_valid_q <= last.res_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign face_o      = face_q;
  assign tex_u_o     = tex_u_q;
  assign tex_v_o     = tex_v_q;
  assign valid_res_o = res_valid_q;

`ifndef SYNTHESIS
  // A zero vector leaves all result fields at zero.
  a_zero_vec_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !valid_res_o |-> face_o == FacePosX && tex_u_o == '0 && tex_v_o == '0)
    else $error("zero vector result has nonzero fields");

  // A valid result names one of the six faces.
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && valid_res_o |-> face_o <= FaceNegZ)
    else $error("face code out of range");

  // The input side only stalls when the output holds an item that is stalled.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // With the output free, the last divider stage always drains.
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i && stg_valid[NumDivStages] |=> out_valid_o)
    else $error("item lost at output register");
`endif

endmodule
